>>> hdl/crwr_pkg.sv
// Shared types and constants for the CSR row weighted reduction block.
// No dependencies; every other file in hdl/ refers to it by scoped names.

package crwr_pkg;

    // Lane geometry
    localparam int NUM_OUT       = 8;      // result lanes on the port
    localparam int LANES         = 8;      // active lanes, 1..NUM_OUT
    localparam int DATA_W        = 16;     // Q8.8 word
    localparam int ACC_W         = 32;     // per-lane accumulator
    localparam int CNT_W         = 16;
    localparam int MAX_ROW_EDGES = 65535;  // edge count saturates here
    localparam int DIV_CNT_W     = $clog2(ACC_W);

    // Stream word widths
    localparam int IN_DATA_W  = DATA_W * (NUM_OUT + 1);
    localparam int OUT_DATA_W = DATA_W * NUM_OUT;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHT  = 1'd1;

    // Reduction modes; the unused code reduces as a sum
    localparam logic [1:0] MODE_SUM  = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;

    typedef logic signed [DATA_W-1:0] lane_word_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FIN,
        ST_DIV,
        ST_LOAD
    } state_t;

    // Control broadcast from the sequencer to every lane
    typedef struct packed {
        logic use_weight;
        logic mode_max;
        logic mode_mean;
        logic acc_en;
        logic first;
        logic div_start;
        logic div_step;
    } lane_ctrl_t;

endpackage

>>> hdl/crwr_lane.sv
// One reduction lane: weight multiply, Q8.8 rounding, running sum or max,
// and a radix-2 divider for the mean. Depends on crwr_pkg.

module crwr_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  crwr_pkg::lane_ctrl_t                ctrl,
    input  logic signed [crwr_pkg::DATA_W-1:0]  weight,
    input  logic signed [crwr_pkg::DATA_W-1:0]  feat,
    input  logic        [crwr_pkg::CNT_W-1:0]   edge_count,
    output crwr_pkg::lane_word_t                result
);

    localparam int DW = crwr_pkg::DATA_W;
    localparam int AW = crwr_pkg::ACC_W;
    localparam int CW = crwr_pkg::CNT_W;
    localparam int FRAC = 8;

    localparam logic signed [AW-1:0] HALF_LSB = AW'(1 << (FRAC - 1));
    localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN  = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [DW-1:0] W_MAX    = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] W_MIN    = {1'b1, {(DW-1){1'b0}}};

    logic signed [AW-1:0]      prod_w;
    logic signed [AW-1:0]      prod_reg;
    logic signed [AW-1:0]      rnd;
    logic signed [AW-FRAC-1:0] shifted;
    logic signed [DW-1:0]      v_next;
    logic signed [DW-1:0]      v_reg;
    logic signed [AW:0]        sum_wide;
    logic signed [AW-1:0]      sum_sat;
    logic signed [AW-1:0]      v_ext;
    logic signed [AW-1:0]      acc_next;
    logic signed [AW-1:0]      acc_reg;
    logic                      neg_reg;
    logic        [AW-1:0]      q_reg;
    logic        [CW-1:0]      rem_reg;
    logic        [CW:0]        trial;
    logic        [CW:0]        trial_diff;
    logic                      trial_ge;
    logic signed [DW-1:0]      mean_sat;
    logic signed [DW-1:0]      acc_sat;

    // Stage 1: product, or the feature lifted to Q16.16 when weights are off
    assign prod_w = weight * feat;

    always_ff @(posedge clk)
    begin
        if (ctrl.use_weight)
        begin
            prod_reg <= prod_w;
        end
        else
        begin
            prod_reg <= {{(AW-DW-FRAC){feat[DW-1]}}, feat, {FRAC{1'b0}}};
        end
    end

    // Stage 2: round half up to Q8.8 and saturate
    assign rnd     = prod_reg + HALF_LSB;
    assign shifted = rnd[AW-1:FRAC];

    always_comb
    begin
        if (shifted[AW-FRAC-1:DW-1] == '0 || shifted[AW-FRAC-1:DW-1] == '1)
        begin
            v_next = shifted[DW-1:0];
        end
        else if (shifted[AW-FRAC-1])
        begin
            v_next = W_MIN;
        end
        else
        begin
            v_next = W_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    // Stage 3: accumulate; the first edge of a row loads in every mode
    assign v_ext    = {{(AW-DW){v_reg[DW-1]}}, v_reg};
    assign sum_wide = {acc_reg[AW-1], acc_reg} + {v_ext[AW-1], v_ext};

    always_comb
    begin
        if (sum_wide[AW] != sum_wide[AW-1])
        begin
            sum_sat = sum_wide[AW] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_sat = sum_wide[AW-1:0];
        end
    end

    always_comb
    begin
        if (ctrl.first)
        begin
            acc_next = v_ext;
        end
        else if (ctrl.mode_max)
        begin
            acc_next = (v_ext > acc_reg) ? v_ext : acc_reg;
        end
        else
        begin
            acc_next = sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Mean: restoring divide of |acc| by the edge count, one bit per cycle
    assign trial      = {rem_reg, q_reg[AW-1]};
    assign trial_ge   = trial >= {1'b0, edge_count};
    assign trial_diff = trial - {1'b0, edge_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
        end
        else if (ctrl.div_start)
        begin
            neg_reg <= acc_reg[AW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            q_reg   <= acc_reg[AW-1] ? AW'(-acc_reg) : acc_reg;
            rem_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            q_reg   <= {q_reg[AW-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
        end
    end

    // Saturate the quotient magnitude with its sign
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > AW'(1 << (DW - 1)))
            begin
                mean_sat = W_MIN;
            end
            else
            begin
                mean_sat = -q_reg[DW-1:0];
            end
        end
        else
        begin
            if (q_reg > AW'(W_MAX))
            begin
                mean_sat = W_MAX;
            end
            else
            begin
                mean_sat = q_reg[DW-1:0];
            end
        end
    end

    always_comb
    begin
        if (acc_reg > AW'(W_MAX))
        begin
            acc_sat = W_MAX;
        end
        else if (acc_reg < AW'(W_MIN))
        begin
            acc_sat = W_MIN;
        end
        else
        begin
            acc_sat = acc_reg[DW-1:0];
        end
    end

    assign result = ctrl.mode_mean ? mean_sat : acc_sat;

endmodule

>>> hdl/crwr_merge.sv
// Merging stage: packs the lane results into one output word and holds it
// in the output register until taken. Depends on crwr_pkg.

module crwr_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 zero,
    input  crwr_pkg::lane_word_t                 lane_res [crwr_pkg::NUM_OUT],
    output logic                                 free,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [crwr_pkg::OUT_DATA_W-1:0]      m_data
);

    localparam int DW = crwr_pkg::DATA_W;

    logic                               valid_reg;
    logic [crwr_pkg::OUT_DATA_W-1:0]    data_reg;
    logic [crwr_pkg::OUT_DATA_W-1:0]    data_next;

    // Empty rows report zero on every lane
    always_comb
    begin
        for (int k = 0; k < crwr_pkg::NUM_OUT; k++)
        begin
            data_next[k*DW +: DW] = zero ? '0 : lane_res[k];
        end
    end

    assign free = !valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> hdl/csr_row_weighted_reduce.sv
// Top level of the CSR row weighted reduction block: configuration, edge
// pipeline sequencing, row finalisation. Depends on crwr_pkg, crwr_lane, crwr_merge.

// Each input word is one edge of a CSR row: a Q8.8 edge weight and eight
// gathered Q8.8 features. Every lane multiplies its feature by the weight
// (or takes it unchanged when use_weight is 0), rounds half up to Q8.8,
// saturates, and folds it into a per-lane sum or maximum. Edges of a row
// stream in at one word per cycle through a three-stage lane pipeline
// (multiply, round, accumulate). A word with tlast ends the row and a word
// with tuser set is an empty row, which reports all zeros and drops any
// partial row. After such a word tready stays low while the pipeline drains
// and the result is formed; for mean, each lane first runs a 32-step
// restoring divide of its sum by the edge count (truncated toward zero).
// tready rises again once the output register is loaded. A result waiting
// in the output register holds tready low only if the next row end arrives
// before the earlier result is taken. Configuration writes are expected
// only while the block is idle.

module csr_row_weighted_reduce (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [crwr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [crwr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // edge words
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // edge_weight, feat_0 .. feat_7 (16 bits each, lowest first)
    input  logic [crwr_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic                                  s_axis_tlast,   // row_end
    input  logic                                  s_axis_tuser,   // row_empty
    // result words
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_0 .. out_7 (16 bits each, lowest first)
    output logic [crwr_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int DW = crwr_pkg::DATA_W;
    localparam int CW = crwr_pkg::CNT_W;
    localparam int DCW = crwr_pkg::DIV_CNT_W;
    localparam logic [CW-1:0]  CNT_LIMIT = CW'(crwr_pkg::MAX_ROW_EDGES);
    localparam logic [DCW-1:0] DIV_LAST  = DCW'(crwr_pkg::ACC_W - 1);

    // Configuration registers
    logic [1:0] mode_reg;
    logic       use_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= crwr_pkg::MODE_SUM;
            use_weight_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == crwr_pkg::REG_REDUCE_MODE)
            begin
                mode_reg <= cfg_wdata[1:0];
            end
            if (cfg_index == crwr_pkg::REG_USE_WEIGHT)
            begin
                use_weight_reg <= cfg_wdata[0];
            end
        end
    end

    logic mode_mean;
    logic mode_max;

    assign mode_mean = (mode_reg == crwr_pkg::MODE_MEAN);
    assign mode_max  = (mode_reg == crwr_pkg::MODE_MAX);

    // Input acceptance: hold off after a row-closing word until its result is loaded
    logic accept;
    logic busy_reg;
    logic load;
    logic out_free;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept && (s_axis_tlast || s_axis_tuser))
        begin
            busy_reg <= 1'b1;
        end
        else if (load)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Word flags travelling alongside the lane pipeline
    logic p1_valid_reg;
    logic p1_end_reg;
    logic p1_empty_reg;
    logic p2_valid_reg;
    logic p2_end_reg;
    logic p2_empty_reg;
    logic p2_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_end_reg   <= s_axis_tlast;
        p1_empty_reg <= s_axis_tuser;
        p2_end_reg   <= p1_end_reg;
        p2_empty_reg <= p1_empty_reg;
    end

    assign p2_last = p2_valid_reg && (p2_end_reg || p2_empty_reg);

    // Row edge count, saturating; zero marks the first edge of a row
    logic          acc_en;
    logic [CW-1:0] cnt_reg;

    assign acc_en = p2_valid_reg && !p2_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (acc_en && cnt_reg != CNT_LIMIT)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Finalisation sequencer
    crwr_pkg::state_t state_reg;
    crwr_pkg::state_t state_next;
    logic             fin_empty_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic             div_start;
    logic             div_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crwr_pkg::ST_RUN;
            fin_empty_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (p2_last)
            begin
                fin_empty_reg <= p2_empty_reg;
            end
            if (div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crwr_pkg::ST_RUN:
            begin
                if (p2_last)
                begin
                    state_next = crwr_pkg::ST_FIN;
                end
            end
            crwr_pkg::ST_FIN:
            begin
                state_next = (mode_mean && !fin_empty_reg) ? crwr_pkg::ST_DIV
                                                           : crwr_pkg::ST_LOAD;
            end
            crwr_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = crwr_pkg::ST_LOAD;
                end
            end
            crwr_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = crwr_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = crwr_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_step  = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            crwr_pkg::ST_RUN:
            begin
            end
            crwr_pkg::ST_FIN:
            begin
                div_start = mode_mean && !fin_empty_reg;
            end
            crwr_pkg::ST_DIV:
            begin
                div_step = 1'b1;
            end
            crwr_pkg::ST_LOAD:
            begin
                load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Lane control broadcast
    crwr_pkg::lane_ctrl_t ctrl;

    always_comb
    begin
        ctrl.use_weight = use_weight_reg;
        ctrl.mode_max   = mode_max;
        ctrl.mode_mean  = mode_mean;
        ctrl.acc_en     = acc_en;
        ctrl.first      = (cnt_reg == '0);
        ctrl.div_start  = div_start;
        ctrl.div_step   = div_step;
    end

    // Lanes; unused lanes report zero
    crwr_pkg::lane_word_t lane_res [crwr_pkg::NUM_OUT];

    for (genvar k = 0; k < crwr_pkg::NUM_OUT; k++)
    begin : g_lane
        if (k < crwr_pkg::LANES)
        begin : g_active
            crwr_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .weight     (s_axis_tdata[DW-1:0]),
                .feat       (s_axis_tdata[(k+1)*DW +: DW]),
                .edge_count (cnt_reg),
                .result     (lane_res[k])
            );
        end
        else
        begin : g_idle
            assign lane_res[k] = '0;
        end
    end

    crwr_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .zero     (fin_empty_reg),
        .lane_res (lane_res),
        .free     (out_free),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_axis_tdata)
    );

endmodule

>>> hdl/crwr_checker.sv
// Port-level checks for csr_row_weighted_reduce, attached by bind.
// Depends on crwr_pkg for the stream widths.

module crwr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tlast,
    input logic                               s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [crwr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic row_close;

    assign row_close = s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A row-closing word stops intake while the row is finalised
    a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
        row_close |=> !s_axis_tready)
        else $error("intake open right after a row-closing word");

    // A new result does not follow a row-closing word at once
    a_close_lead: assert property (@(posedge clk) disable iff (!rst_n)
        row_close |=> !m_axis_tvalid || !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after a row-closing word");

    // A new result is only loaded while intake is held off
    a_load_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result loaded while intake was open");

endmodule

bind csr_row_weighted_reduce crwr_checker u_crwr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/csr_row_weighted_reduce_test.sv
// Self-checking testbench for csr_row_weighted_reduce: edge words in, reduced row words out.
// Depends on crwr_pkg and the block's RTL; predicts every row result and compares per lane.

module csr_row_weighted_reduce_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth mode code has no name in the package; it reduces as a sum
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Longer mean row sent back to back; the tail edges swing lanes 0 to 3
    // to the opposite extreme
    localparam int LONG_ROW_EDGES = 80;
    localparam int LONG_ROW_TURN  = 70;

    // Quiet period before a register write: covers the mean finish
    localparam int SETTLE_CYCLES  = 50;

    // Print at most this many mismatch lines; keep counting beyond it
    localparam int REPORT_CAP     = 200;

    // One edge word as the block sees it; feat[0] sits just above the weight
    typedef struct packed {
        logic                                           row_empty;
        logic                                           row_end;
        crwr_pkg::lane_word_t [crwr_pkg::NUM_OUT-1:0]   feat;
        crwr_pkg::lane_word_t                           weight;
    } edge_word_t;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_we        = 1'b0;
    logic [crwr_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [crwr_pkg::CFG_DATA_W-1:0]      cfg_wdata     = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [crwr_pkg::IN_DATA_W-1:0]       s_axis_tdata  = '0;
    logic                                 s_axis_tlast  = 1'b0;
    logic                                 s_axis_tuser  = 1'b0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [crwr_pkg::OUT_DATA_W-1:0]      m_axis_tdata;

    // Predictor state: its own copy of the registers and the row in progress
    logic [1:0]                           cur_mode     = crwr_pkg::MODE_SUM;
    logic                                 cur_weighted = 1'b0;
    logic signed [crwr_pkg::ACC_W-1:0]    lane_acc [crwr_pkg::NUM_OUT];
    logic [crwr_pkg::CNT_W-1:0]           edge_cnt     = '0;

    // Expected row results, oldest first
    logic [crwr_pkg::OUT_DATA_W-1:0]      pending_rows [$];

    int                       mismatches = 0;
    int                       tx_quiet   = 0;   // edges still to send back to back
    int                       rx_hold    = 0;   // long hold-off requested of the receiver

    csr_row_weighted_reduce i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic crwr_pkg::lane_word_t sat16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return crwr_pkg::lane_word_t'(v);
    endfunction

    function automatic logic signed [crwr_pkg::ACC_W-1:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[crwr_pkg::ACC_W-1:0];
    endfunction

    // Weight the feature in Q8.8: round half up (floor of p + 0.5), saturate
    function automatic crwr_pkg::lane_word_t weigh(input crwr_pkg::lane_word_t w,
                                                   input crwr_pkg::lane_word_t f);
        longint p;
        if (!cur_weighted)
            return f;
        p = longint'(w) * longint'(f) + 128;
        return sat16(p >>> 8);
    endfunction

    task automatic restart_row();
        foreach (lane_acc[l])
            lane_acc[l] = '0;
        edge_cnt = '0;
    endtask

    // Fold one accepted edge word into the row; queue the row word at its end
    task automatic fold_edge(input edge_word_t e);
        logic [crwr_pkg::OUT_DATA_W-1:0] row_out;
        crwr_pkg::lane_word_t            v;
        longint                          r;
        row_out = '0;
        // An empty row reports zeros and drops whatever was in progress
        if (e.row_empty)
        begin
            pending_rows.push_back(row_out);
            restart_row();
            return;
        end
        for (int l = 0; l < crwr_pkg::LANES; l++)
        begin
            v = weigh(e.weight, e.feat[l]);
            // The first edge loads the lane in every mode
            if (edge_cnt == 0)
                lane_acc[l] = crwr_pkg::ACC_W'(v);
            else if (cur_mode == crwr_pkg::MODE_MAX)
            begin
                if (v > lane_acc[l])
                    lane_acc[l] = crwr_pkg::ACC_W'(v);
            end
            else
                lane_acc[l] = sat32(longint'(lane_acc[l]) + longint'(v));
        end
        if (edge_cnt < crwr_pkg::MAX_ROW_EDGES)
            edge_cnt++;
        if (!e.row_end)
            return;
        // Finish with the mode in force at the row end; mean truncates toward zero
        for (int l = 0; l < crwr_pkg::LANES; l++)
        begin
            r = longint'(lane_acc[l]);
            if (cur_mode == crwr_pkg::MODE_MEAN)
                r = r / longint'(edge_cnt);
            row_out[l*crwr_pkg::DATA_W +: crwr_pkg::DATA_W] = sat16(r);
        end
        pending_rows.push_back(row_out);
        restart_row();
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random Q8.8 word, biased towards the extremes and, for weights, unity
    function automatic crwr_pkg::lane_word_t rand_q88(input bit as_weight);
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return as_weight ? 16'sh0100
                                      : crwr_pkg::lane_word_t'($urandom_range(0, 1023) - 512);
            3:       return as_weight ? -16'sh0100
                                      : crwr_pkg::lane_word_t'($urandom_range(0, 63) - 32);
            4:       return crwr_pkg::lane_word_t'($urandom_range(0, 2047) - 1024);
            default: return crwr_pkg::lane_word_t'($urandom);
        endcase
    endfunction

    function automatic edge_word_t rand_edge();
        edge_word_t e;
        e.weight = rand_q88(1'b1);
        for (int l = 0; l < crwr_pkg::NUM_OUT; l++)
            e.feat[l] = rand_q88(1'b0);
        e.row_end   = 1'b0;
        e.row_empty = 1'b0;
        return e;
    endfunction

    function automatic edge_word_t uniform_edge(input crwr_pkg::lane_word_t w,
                                                input crwr_pkg::lane_word_t f,
                                                input logic last);
        edge_word_t e;
        e.weight = w;
        for (int l = 0; l < crwr_pkg::NUM_OUT; l++)
            e.feat[l] = f;
        e.row_end   = last;
        e.row_empty = 1'b0;
        return e;
    endfunction

    // Offer one edge word after a random gap, hold it until accepted, then
    // fold it into the prediction. Called and left just after a rising edge.
    task automatic send_edge(input edge_word_t e);
        int gap;
        if (tx_quiet > 0)
        begin
            gap = 0;
            tx_quiet--;
        end
        else
        begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0)
                tx_quiet = $urandom_range(10, 60);
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e.feat, e.weight};
        s_axis_tlast  <= e.row_end;
        s_axis_tuser  <= e.row_empty;
        do
            @(posedge clk);
        while (!s_axis_tready);
        fold_edge(e);
    endtask

    // Write a register once the block has gone quiet: drop valid, wait for
    // every expected row word, then let the pipeline and divider drain
    task automatic set_register(input logic [crwr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [crwr_pkg::CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == crwr_pkg::REG_REDUCE_MODE)
            cur_mode = value;
        else
            cur_weighted = value[0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain sums: lane extremes, 16-bit output saturation, empty rows
    task automatic test_sum_extremes();
        edge_word_t e;
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_SUM);
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd0);
        e = uniform_edge(16'sh1234, 16'sh7FFF, 1'b1);
        e.feat[1] = 16'sh8000;
        e.feat[2] = 16'sh0000;
        e.feat[3] = -16'sh0001;
        e.feat[4] = 16'sh0001;
        e.feat[5] = 16'sh5555;
        e.feat[6] = 16'shAAAA;
        send_edge(e);
        // Two-word row that runs past 16 bits both ways
        e = uniform_edge(16'sh0000, 16'sh7FFF, 1'b0);
        for (int l = 4; l < crwr_pkg::NUM_OUT; l++)
            e.feat[l] = 16'sh8000;
        send_edge(e);
        e.row_end = 1'b1;
        send_edge(e);
        // Partial row cut short by an empty row with junk in the other fields
        send_edge(uniform_edge(16'sh0000, 16'sh0064, 1'b0));
        e = rand_edge();
        e.row_empty = 1'b1;
        e.row_end   = 1'b1;
        send_edge(e);
        // Next row must start from clean lanes
        send_edge(uniform_edge(16'sh0000, 16'sh0005, 1'b1));
        // Empty row on its own, without tlast
        e = rand_edge();
        e.row_empty = 1'b1;
        send_edge(e);
    endtask

    // Weighted products: unity, half-way rounding, saturation, zero weight
    task automatic test_weighted_rounding();
        edge_word_t e;
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd1);
        e = rand_edge();
        e.weight  = 16'sh0100;
        e.row_end = 1'b1;
        send_edge(e);
        e = uniform_edge(16'sh0080, 16'sh0001, 1'b1);
        e.feat[1] = -16'sh0001;
        e.feat[2] = 16'sh0003;
        e.feat[3] = -16'sh0003;
        e.feat[4] = 16'sh7FFF;
        e.feat[5] = 16'sh8000;
        e.feat[6] = 16'sh0002;
        e.feat[7] = -16'sh0002;
        send_edge(e);
        e = uniform_edge(16'sh7FFF, 16'sh7FFF, 1'b1);
        e.feat[1] = 16'sh8000;
        e.feat[2] = 16'sh0100;
        e.feat[3] = -16'sh0100;
        send_edge(e);
        e = uniform_edge(16'sh8000, 16'sh8000, 1'b1);
        e.feat[1] = 16'sh7FFF;
        e.feat[2] = 16'sh0001;
        send_edge(e);
        send_edge(uniform_edge(16'sh0000, 16'sh7FFF, 1'b1));
    endtask

    // Mean: truncation toward zero on negative sums, single-edge rows
    task automatic test_mean_mode();
        edge_word_t e;
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_MEAN);
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd0);
        e = uniform_edge(16'sh0000, -16'sh0001, 1'b0);
        for (int l = 4; l < crwr_pkg::NUM_OUT; l++)
            e.feat[l] = 16'sh0007;
        send_edge(e);
        send_edge(e);
        e = uniform_edge(16'sh0000, 16'sh0000, 1'b1);
        for (int l = 4; l < crwr_pkg::NUM_OUT; l++)
            e.feat[l] = 16'sh8000;
        send_edge(e);
        send_edge(uniform_edge(16'sh0000, 16'sh8000, 1'b1));
    endtask

    // Max: negative values load on the first edge; the spare code sums
    task automatic test_max_and_spare_mode();
        edge_word_t e;
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_MAX);
        send_edge(uniform_edge(16'sh0000, -16'sh0005, 1'b0));
        e = uniform_edge(16'sh0000, -16'sh0003, 1'b0);
        e.feat[0] = 16'sh8000;
        send_edge(e);
        e = uniform_edge(16'sh0000, -16'sh0009, 1'b1);
        e.feat[1] = 16'sh7FFF;
        send_edge(e);
        set_register(crwr_pkg::REG_REDUCE_MODE, MODE_UNUSED);
        // Write bit 1 as well; only bit 0 selects weighting
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd3);
        send_edge(uniform_edge(16'sh0100, 16'sh0011, 1'b0));
        send_edge(uniform_edge(16'sh0100, -16'sh0033, 1'b1));
    endtask

    // Mode switched with a row in progress: edges fold under their own mode,
    // the row finishes under the mode at its end
    task automatic test_mode_change_in_row();
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_SUM);
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd0);
        send_edge(uniform_edge(16'sh0000, 16'sh0010, 1'b0));
        send_edge(uniform_edge(16'sh0000, 16'sh0020, 1'b0));
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_MAX);
        send_edge(uniform_edge(16'sh0000, 16'sh0008, 1'b0));
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_MEAN);
        send_edge(uniform_edge(16'sh0000, -16'sh0002, 1'b1));
    endtask

    // One longer mean row, back to back: large sums of both signs that the
    // tail edges pull back the other way
    task automatic test_long_row();
        edge_word_t e;
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_MEAN);
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd0);
        tx_quiet = LONG_ROW_EDGES;
        for (int k = 0; k < LONG_ROW_EDGES; k++)
        begin
            e = uniform_edge(rand_q88(1'b1), 16'sh4000, k == LONG_ROW_EDGES - 1);
            e.feat[0] = (k < LONG_ROW_TURN) ? 16'sh7FFF : 16'sh8000;
            e.feat[1] = e.feat[0];
            e.feat[2] = (k < LONG_ROW_TURN) ? 16'sh8000 : 16'sh7FFF;
            e.feat[3] = e.feat[2];
            e.feat[5] = -16'sh4000;
            e.feat[6] = rand_q88(1'b0);
            e.feat[7] = 16'sh0001;
            send_edge(e);
        end
        tx_quiet = 0;
    endtask

    // Random rows of random length, with empty-row noise and rows broken
    // off by an empty word, under a series of register settings
    task automatic test_random_rows();
        logic [1:0] phase_mode [7];
        logic [1:0] phase_weight [7];
        edge_word_t e;
        int         sent;
        int         len;
        bit         broken;
        phase_mode   = '{crwr_pkg::MODE_SUM, crwr_pkg::MODE_MEAN, crwr_pkg::MODE_MAX,
                         crwr_pkg::MODE_SUM, crwr_pkg::MODE_MEAN, crwr_pkg::MODE_MAX,
                         MODE_UNUSED};
        phase_weight = '{2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1};
        for (int p = 0; p < 7; p++)
        begin
            set_register(crwr_pkg::REG_REDUCE_MODE, phase_mode[p]);
            set_register(crwr_pkg::REG_USE_WEIGHT, phase_weight[p]);
            sent = 0;
            while (sent < ((p < 6) ? 200 : 100))
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    e = rand_edge();
                    e.row_empty = 1'b1;
                    e.row_end   = 1'($urandom_range(0, 1));
                    send_edge(e);
                    sent++;
                end
                else
                begin
                    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                         : $urandom_range(1, 6);
                    broken = ($urandom_range(0, 19) == 0);
                    for (int k = 0; k < len; k++)
                    begin
                        e = rand_edge();
                        e.row_end = (k == len - 1);
                        if (broken && k == len - 1)
                        begin
                            e.row_empty = 1'b1;
                            e.row_end   = 1'($urandom_range(0, 1));
                        end
                        send_edge(e);
                    end
                    sent += len;
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while short rows keep coming:
    // the output register fills and the block must stall its input
    task automatic test_output_backpressure();
        edge_word_t e;
        int         len;
        set_register(crwr_pkg::REG_REDUCE_MODE, crwr_pkg::MODE_SUM);
        set_register(crwr_pkg::REG_USE_WEIGHT, 2'd1);
        rx_hold  = 300;
        tx_quiet = 120;
        for (int r = 0; r < 40; r++)
        begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
            begin
                e = rand_edge();
                e.row_end = (k == len - 1);
                send_edge(e);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random tready gaps, quiet stretches, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        int rx_quiet;
        rx_quiet = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold != 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else if (rx_quiet != 0)
            begin
                stall = 0;
                rx_quiet--;
            end
            else
            begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = $urandom_range(10, 60);
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            // Hold tready high until a result word is taken
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare every accepted result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [crwr_pkg::OUT_DATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                if (mismatches < REPORT_CAP)
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_rows.pop_front();
                for (int l = 0; l < crwr_pkg::NUM_OUT; l++)
                begin
                    if (want[l*crwr_pkg::DATA_W +: crwr_pkg::DATA_W] !==
                        m_axis_tdata[l*crwr_pkg::DATA_W +: crwr_pkg::DATA_W])
                    begin
                        if (mismatches < REPORT_CAP)
                            $display("%0t: out_%0d mismatch, expected %0d, actual %0d",
                                     $time, l,
                                     $signed(want[l*crwr_pkg::DATA_W +: crwr_pkg::DATA_W]),
                                     $signed(m_axis_tdata[l*crwr_pkg::DATA_W +:
                                                          crwr_pkg::DATA_W]));
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        restart_row();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sum_extremes();
        test_weighted_rounding();
        test_mean_mode();
        test_max_and_spare_mode();
        test_mode_change_in_row();
        test_long_row();
        test_random_rows();
        test_output_backpressure();
        s_axis_tvalid <= 1'b0;
        // Drain: every predicted word must arrive, then watch for strays
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
hdl/crwr_pkg.sv
hdl/crwr_lane.sv
hdl/crwr_merge.sv
hdl/csr_row_weighted_reduce.sv
hdl/crwr_checker.sv
verif/csr_row_weighted_reduce_test.sv
